@@ src/posting_delta_vbyte_encoder_defines.svh @@
// Assertion macros shared by the posting encoder RTL.
`ifndef POSTING_DELTA_VBYTE_ENCODER_DEFINES_SVH
`define POSTING_DELTA_VBYTE_ENCODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PDVE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdve assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PDVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdve assertion failed");

`endif

@@ src/pdve_pkg.sv @@
// Types, constants and helper functions of the posting encoder.
package pdve_pkg;

    localparam int MAX_CODE_BYTES = 5;
    localparam int GROUP_BITS     = 7;
    localparam int DOC_W          = 32;
    localparam int TERM_W         = 32;
    localparam int COUNT_W        = 32;
    localparam int OFFSET_W       = 48;
    localparam int TERM_IDX_W     = $clog2(TERM_W);
    localparam int CNT_W          = $clog2(MAX_CODE_BYTES + 1);
    // Queue depth between front and back; a power of two, at least two.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CONT_FLAG = 8'd128;

    localparam logic ACT_POSTING = 1'b0;
    localparam logic ACT_END     = 1'b1;
    localparam logic KIND_CODE   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic              action;
        logic [DOC_W-1:0]  doc_id;
        logic [TERM_W-1:0] term_id;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic [7:0]          code_byte;
        logic [DOC_W-1:0]    record_doc;
        logic [COUNT_W-1:0]  record_count;
        logic [COUNT_W-1:0]  record_bytes;
        logic [OFFSET_W-1:0] record_offset;
        logic                last;
    } t_result;

    typedef struct packed {
        logic               rec;
        logic [DOC_W-1:0]   rec_doc;
        logic [COUNT_W-1:0] rec_count;
        logic               code;
        logic [TERM_W-1:0]  value;
        t_cnt               nbytes;
        logic               eos;
    } t_job;

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    function automatic logic [GROUP_BITS-1:0] code_group(logic [TERM_W-1:0] v, t_cnt idx);
        logic [GROUP_BITS-1:0] g;
        int pos;
        g = '0;
        for (int x = 0; x < MAX_CODE_BYTES; x++) begin
            if (idx == CNT_W'(x)) begin
                for (int b = 0; b < GROUP_BITS; b++) begin
                    pos = x * GROUP_BITS + b;
                    if (pos < TERM_W) begin
                        g[b] = v[pos[TERM_IDX_W-1:0]];
                    end
                end
            end
        end
        return g;
    endfunction

    function automatic t_cnt code_len(logic [TERM_W-1:0] v);
        t_cnt n;
        n = CNT_W'(1);
        for (int x = 1; x < MAX_CODE_BYTES; x++) begin
            if (code_group(v, CNT_W'(x)) != '0) begin
                n = CNT_W'(x + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ src/pdve_front.sv @@
// Front end: tracks the open document; turns each posting, and each end that closes a document, into a job.
module pdve_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  pdve_pkg::t_in_item i_item,
    output logic              o_job_push,
    output pdve_pkg::t_job    o_job
);

    logic                           r_open;
    logic [pdve_pkg::DOC_W-1:0]     r_doc;
    logic [pdve_pkg::TERM_W-1:0]    r_prev;
    logic [pdve_pkg::COUNT_W-1:0]   r_count;
    logic                           n_open;
    logic [pdve_pkg::DOC_W-1:0]     n_doc;
    logic [pdve_pkg::TERM_W-1:0]    n_prev;
    logic [pdve_pkg::COUNT_W-1:0]   n_count;
    logic                           doc_change;
    logic                           new_group;
    logic [pdve_pkg::TERM_W-1:0]    value;

    assign doc_change = r_open && (i_item.doc_id != r_doc);
    assign new_group  = !r_open || doc_change;
    assign value      = new_group ? i_item.term_id : i_item.term_id - r_prev;

    always_comb begin
        o_job.rec_doc   = r_doc;
        o_job.rec_count = r_count;
        o_job.value     = value;
        o_job.nbytes    = pdve_pkg::code_len(value);
        n_open          = r_open;
        n_doc           = r_doc;
        n_prev          = r_prev;
        n_count         = r_count;
        if (i_item.action == pdve_pkg::ACT_END) begin
            o_job.rec  = r_open;
            o_job.code = 1'b0;
            o_job.eos  = 1'b1;
            o_job_push = i_accept && r_open;
            n_open     = 1'b0;
            n_doc      = '0;
            n_prev     = '0;
            n_count    = '0;
        end else begin
            o_job.rec  = doc_change;
            o_job.code = 1'b1;
            o_job.eos  = 1'b0;
            o_job_push = i_accept;
            n_open     = 1'b1;
            n_doc      = i_item.doc_id;
            n_prev     = i_item.term_id;
            n_count    = new_group ? pdve_pkg::COUNT_W'(1) : pdve_pkg::sat_inc(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_doc   <= '0;
            r_prev  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_open  <= n_open;
            r_doc   <= n_doc;
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

endmodule

@@ src/pdve_queue.sv @@
// Short job queue that decouples the front end from the byte emitter.
module pdve_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pdve_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output pdve_pkg::t_job o_data,
    output logic           o_empty
);

    pdve_pkg::t_job                r_mem [pdve_pkg::QUEUE_DEPTH];
    logic [pdve_pkg::QPTR_W-1:0]   r_wr;
    logic [pdve_pkg::QPTR_W-1:0]   r_rd;
    logic [pdve_pkg::QPTR_W:0]     r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == (pdve_pkg::QPTR_W + 1)'(pdve_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + pdve_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + pdve_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (pdve_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (pdve_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ src/pdve_back.sv @@
// Back end: emits records and code bytes into the output register, one per cycle while it is empty or being popped.
module pdve_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  pdve_pkg::t_job    i_job,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output pdve_pkg::t_result o_result
);

    logic                           r_out_valid;
    pdve_pkg::t_result              r_out;
    logic                           r_rec_done;
    pdve_pkg::t_cnt                 r_sent;
    logic [pdve_pkg::COUNT_W-1:0]   r_bytes;
    logic [pdve_pkg::OFFSET_W-1:0]  r_offset;
    logic                           emit;
    logic                           emit_rec;
    pdve_pkg::t_cnt                 grp;
    logic                           grp_last;
    pdve_pkg::t_result              n_out;

    assign emit     = i_job_valid && (!r_out_valid || i_pop);
    assign emit_rec = i_job.rec && !r_rec_done;
    assign grp      = i_job.nbytes - pdve_pkg::CNT_W'(1) - r_sent;
    assign grp_last = (grp == '0);
    assign o_job_pop = emit && (emit_rec ? !i_job.code : grp_last);
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out = '0;
        if (emit_rec) begin
            n_out.kind          = pdve_pkg::KIND_RECORD;
            n_out.record_doc    = i_job.rec_doc;
            n_out.record_count  = i_job.rec_count;
            n_out.record_bytes  = r_bytes;
            n_out.record_offset = r_offset;
            n_out.last          = !i_job.code;
        end else begin
            n_out.kind      = pdve_pkg::KIND_CODE;
            n_out.code_byte = {1'b0, pdve_pkg::code_group(i_job.value, grp)}
                              | (grp_last ? 8'd0 : pdve_pkg::CONT_FLAG);
            n_out.last      = grp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rec_done  <= 1'b0;
            r_sent      <= '0;
            r_bytes     <= '0;
            r_offset    <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                if (emit_rec) begin
                    r_bytes    <= '0;
                    r_offset   <= i_job.eos ? '0
                                  : r_offset + pdve_pkg::OFFSET_W'(r_bytes);
                    r_rec_done <= i_job.code;
                end else begin
                    r_bytes <= pdve_pkg::sat_inc(r_bytes);
                    if (grp_last) begin
                        r_sent     <= '0;
                        r_rec_done <= 1'b0;
                    end else begin
                        r_sent <= r_sent + pdve_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

endmodule

@@ src/posting_delta_vbyte_encoder.sv @@
// Variable-byte posting encoder with document records: the top level.
// Postings enter through a queue-style port at up to one per cycle while full is
// low; a front end tracks the open document and writes one job per posting, and
// per end of stream that closes an open document, into a two-entry queue, and a
// back end emits one result per cycle from that job into an output register
// while that register is empty or being popped. An item causes one to five code
// bytes for a posting, plus a record when it closes a document, and a record for
// an end of stream that closes an open document (none otherwise). The back end's
// single byte emitter sets the pace. The first result of an item passes through
// the job queue and the output register before it appears on the result ports.
module posting_delta_vbyte_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  pdve_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output pdve_pkg::t_result o_result
);

`include "posting_delta_vbyte_encoder_defines.svh"

    logic           accept;
    logic           job_push;
    pdve_pkg::t_job front_job;
    pdve_pkg::t_job head_job;
    logic           q_empty;
    logic           job_pop;
    logic           out_is_code;
    logic           posting_accept;

    assign accept = push && !full;

    pdve_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    pdve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (head_job),
        .o_empty (q_empty)
    );

    pdve_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    assign out_is_code    = !empty && (o_result.kind == pdve_pkg::KIND_CODE);
    assign posting_accept = accept && (i_item.action == pdve_pkg::ACT_POSTING);

    `PDVE_ASSERT_SAME(a_cont_flag_vs_last, i_clk, i_rst_n, out_is_code, o_result.last == !o_result.code_byte[7])
    `PDVE_ASSERT_SAME(a_code_has_no_record, i_clk, i_rst_n, out_is_code, o_result.record_doc == '0)
    `PDVE_ASSERT_NEXT(a_posting_lands, i_clk, i_rst_n, posting_accept, !q_empty || !empty)

endmodule

@@ tb/posting_delta_vbyte_encoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking regression bench for the posting delta variable-byte encoder.
module posting_delta_vbyte_encoder_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 320;
    localparam int DRAIN_CYCLES = 20;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    pdve_pkg::t_in_item i_item  = '0;
    logic               empty;
    logic               pop     = 1'b0;
    pdve_pkg::t_result  o_result;

    pdve_pkg::t_in_item posting_queue[$];
    pdve_pkg::t_result  awaited_results[$];
    pdve_pkg::t_result  oldest_result;
    int       error_count     = 0;
    int       cycle_count     = 0;
    int       results_checked = 0;
    int       send_gap        = 0;
    int       recv_stall      = 0;
    int       hold_left       = 0;
    bit       hold_done       = 1'b0;

    // Encoder state as the bench tracks it.
    logic                          doc_open   = 1'b0;
    logic [pdve_pkg::DOC_W-1:0]    open_doc   = '0;
    logic [pdve_pkg::TERM_W-1:0]   last_term  = '0;
    logic [pdve_pkg::COUNT_W-1:0]  doc_terms  = '0;
    logic [pdve_pkg::COUNT_W-1:0]  doc_bytes  = '0;
    logic [pdve_pkg::OFFSET_W-1:0] doc_offset = '0;

    posting_delta_vbyte_encoder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [pdve_pkg::COUNT_W-1:0] count_up(
        logic [pdve_pkg::COUNT_W-1:0] v);
        return (v == '1) ? v : v + pdve_pkg::COUNT_W'(1);
    endfunction

    function automatic pdve_pkg::t_result code_result(logic [7:0] b);
        pdve_pkg::t_result r;
        r = '0;
        r.kind = pdve_pkg::KIND_CODE;
        r.code_byte = b;
        return r;
    endfunction

    function automatic string describe(pdve_pkg::t_result r);
        return $sformatf("kind=%0h byte=%02h doc=%08h count=%08h bytes=%08h offset=%012h last=%0h",
                         r.kind, r.code_byte, r.record_doc, r.record_count,
                         r.record_bytes, r.record_offset, r.last);
    endfunction

    function automatic int idle_length();
        if ((cycle_count / 300) % 3 == 0) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(0, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [pdve_pkg::TERM_W-1:0] term_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 50) return $urandom_range(1, 127);
        if (pick < 75) return $urandom_range(128, 16383);
        if (pick < 90) return $urandom_range(16384, 2097151);
        return $urandom();
    endfunction

    task automatic expect_result(pdve_pkg::t_result r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic close_doc();
        pdve_pkg::t_result r;
        r = '0;
        r.kind = pdve_pkg::KIND_RECORD;
        r.record_doc = open_doc;
        r.record_count = doc_terms;
        r.record_bytes = doc_bytes;
        r.record_offset = doc_offset;
        expect_result(r);
        doc_offset = doc_offset + pdve_pkg::OFFSET_W'(doc_bytes);
    endtask

    task automatic push_code(logic [pdve_pkg::TERM_W-1:0] value);
        logic [pdve_pkg::GROUP_BITS-1:0] groups[pdve_pkg::MAX_CODE_BYTES];
        bit started;
        started = 1'b0;
        for (int x = 0; x < pdve_pkg::MAX_CODE_BYTES; x++) begin
            groups[x] = (x * pdve_pkg::GROUP_BITS < pdve_pkg::TERM_W)
                        ? pdve_pkg::GROUP_BITS'(value >> (x * pdve_pkg::GROUP_BITS)) : '0;
        end
        for (int x = pdve_pkg::MAX_CODE_BYTES - 1; x > 0; x--) begin
            if (groups[x] != '0 || started) begin
                started = 1'b1;
                expect_result(code_result(8'(groups[x]) | pdve_pkg::CONT_FLAG));
                doc_bytes = count_up(doc_bytes);
            end
        end
        expect_result(code_result(8'(groups[0])));
        doc_bytes = count_up(doc_bytes);
    endtask

    task automatic encode_item(pdve_pkg::t_in_item it);
        int first;
        logic [pdve_pkg::TERM_W-1:0] value;
        first = awaited_results.size();
        if (it.action == pdve_pkg::ACT_END) begin
            if (doc_open) close_doc();
            doc_open = 1'b0;
            open_doc = '0;
            last_term = '0;
            doc_terms = '0;
            doc_bytes = '0;
            doc_offset = '0;
        end else begin
            if (doc_open && it.doc_id != open_doc) begin
                close_doc();
                doc_open = 1'b0;
            end
            if (!doc_open) begin
                doc_open = 1'b1;
                open_doc = it.doc_id;
                doc_terms = '0;
                doc_bytes = '0;
                value = it.term_id;
            end else begin
                value = it.term_id - last_term;
            end
            last_term = it.term_id;
            doc_terms = count_up(doc_terms);
            push_code(value);
        end
        if (awaited_results.size() > first) begin
            awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
    endtask

    task automatic add_posting(logic [pdve_pkg::DOC_W-1:0] doc,
                               logic [pdve_pkg::TERM_W-1:0] term);
        pdve_pkg::t_in_item it;
        it.action = pdve_pkg::ACT_POSTING;
        it.doc_id = doc;
        it.term_id = term;
        posting_queue.insert(posting_queue.size(), it);
    endtask

    task automatic add_end();
        pdve_pkg::t_in_item it;
        it.action = pdve_pkg::ACT_END;
        it.doc_id = $urandom();
        it.term_id = $urandom();
        posting_queue.insert(posting_queue.size(), it);
    endtask

    task automatic build_directed();
        add_end();
        add_posting(32'h0, 32'd0);
        add_posting(32'h0, 32'd127);
        add_posting(32'h0, 32'd255);
        add_posting(32'h0, 32'd255);
        add_posting(32'h0, 32'd16638);
        add_posting(32'h0, 32'd33022);
        add_posting(32'h0, 32'd5);
        add_posting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_posting(32'hFFFF_FFFF, 32'h0);
        add_posting(32'h1, 32'd2097151);
        add_posting(32'h2, 32'd2097152);
        add_posting(32'h3, 32'd268435455);
        add_posting(32'h4, 32'd268435456);
        add_posting(32'h4, 32'd268435455);
        add_posting(32'h0, 32'd7);
        add_end();
        add_end();
        add_posting(32'h8000_0000, 32'h8000_0000);
        add_posting(32'h8000_0000, 32'h8000_0080);
        add_end();
    endtask

    task automatic build_random();
        int made;
        int terms;
        int pick;
        logic [pdve_pkg::DOC_W-1:0] doc;
        logic [pdve_pkg::TERM_W-1:0] term;
        logic [pdve_pkg::DOC_W-1:0] seen_docs[4];
        made = 0;
        for (int x = 0; x < 4; x++) seen_docs[x] = $urandom();
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                add_end();
                made++;
            end else if (pick < 10) begin
                add_posting($urandom(), $urandom());
                made++;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6) doc = $urandom();
                else if (pick < 8) doc = $urandom_range(0, 7);
                else doc = seen_docs[$urandom_range(0, 3)];
                seen_docs[$urandom_range(0, 3)] = doc;
                term = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 300);
                terms = $urandom_range(1, 6);
                for (int x = 0; x < terms; x++) begin
                    add_posting(doc, term);
                    term = term + term_gap();
                    made++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    add_end();
                    made++;
                end
            end
        end
        add_end();
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("posting_delta_vbyte_encoder regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                encode_item(i_item);
                send_gap = idle_length();
            end
            if (!(push && full)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (posting_queue.size() != 0) begin
                    i_item <= posting_queue.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result %s", $time, describe(o_result));
                    error_count++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (o_result !== oldest_result) begin
                        $display("%0t: mismatch expected %s actual %s", $time,
                                 describe(oldest_result), describe(o_result));
                        error_count++;
                    end
                end
                results_checked++;
            end
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                recv_stall = idle_length();
                pop <= (recv_stall == 0);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (posting_queue.size() != 0 || push) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("posting_delta_vbyte_encoder regression: pass");
        end else begin
            $display("posting_delta_vbyte_encoder regression: fail");
        end
        $finish;
    end

endmodule
